[rtl/tsl_pkg.sv]
// ----------------------------------------------------------------------------
// tsl_pkg
// shared types and constants for the thruster slew limiter
// ----------------------------------------------------------------------------
package tsl_pkg;

  localparam int TIMER_BITS = 16;
  localparam int TPS_W      = 16;
  localparam int CHANNELS   = 5;
  localparam int SPEED_W    = 8;
  localparam int DUTY_W     = SPEED_W + 1;
  localparam int STEP_W     = 8;
  localparam int STEP_SAT   = 255;
  localparam int TPS_RESET  = 1000;
  localparam int QDEPTH     = 2;
  localparam int QAW        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int REM_W      = ((TIMER_BITS > TPS_W) ? TIMER_BITS : TPS_W) + 1;
  localparam int PROD_W     = STEP_W + TPS_W;
  localparam int CH_W       = $clog2(CHANNELS);
  localparam int DCNT_W     = $clog2(TIMER_BITS);

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_TICK  = 2'd1,
    OP_ALIVE = 2'd2
  } op_t;

  typedef enum logic {
    CMD_SET  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic [CHANNELS-1:0]         mask;
    logic signed [SPEED_W-1:0]   speed;
    logic [TIMER_BITS-1:0]       now;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/tsl_ifs.sv]
// ----------------------------------------------------------------------------
// tsl interfaces
// valid/ready channels for input words, result words and configuration
// ----------------------------------------------------------------------------
interface tsl_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [4:0]        motor_mask;
  logic signed [7:0] target_speed;
  logic [15:0]       timer_now;
  logic              alive_value;

  modport source (output valid, operation, motor_mask, target_speed, timer_now,
                  alive_value, input ready);
  modport sink   (input valid, operation, motor_mask, target_speed, timer_now,
                  alive_value, output ready);
endinterface

interface tsl_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] duty_prop;
  logic       rev_prop;
  logic [8:0] duty_hbow;
  logic       rev_hbow;
  logic [8:0] duty_vbow;
  logic       rev_vbow;
  logic [8:0] duty_hstern;
  logic       rev_hstern;
  logic [8:0] duty_vstern;
  logic       rev_vstern;

  modport source (output valid, duty_prop, rev_prop, duty_hbow, rev_hbow, duty_vbow,
                  rev_vbow, duty_hstern, rev_hstern, duty_vstern, rev_vstern,
                  input ready);
  modport sink   (input valid, duty_prop, rev_prop, duty_hbow, rev_hbow, duty_vbow,
                  rev_vbow, duty_hstern, rev_hstern, duty_vstern, rev_vstern,
                  output ready);
endinterface

interface tsl_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/tsl_front.sv]
// ----------------------------------------------------------------------------
// tsl_front
// accepts input words, tracks the alive flag, queues ticks and, if alive, sets
// ----------------------------------------------------------------------------
module tsl_front (
  input  logic          clk,
  input  logic          rst_n,
  tsl_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output tsl_pkg::cmd_t cmd
);
  import tsl_pkg::*;

  logic alive_r;
  logic alive_nxt;
  logic acc;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;

  always_comb begin
    push      = 1'b0;
    alive_nxt = alive_r;
    cmd.kind  = CMD_SET;
    cmd.mask  = in_ch.motor_mask;
    cmd.speed = in_ch.target_speed;
    cmd.now   = TIMER_BITS'(in_ch.timer_now);
    case (op_t'(in_ch.operation))
      OP_SET: begin
        push = acc && alive_r;
      end
      OP_TICK: begin
        cmd.kind = CMD_TICK;
        push     = acc;
      end
      OP_ALIVE: begin
        if (acc) alive_nxt = in_ch.alive_value;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= 1'b1;
    end else begin
      alive_r <= alive_nxt;
    end
  end

endmodule

[rtl/tsl_fifo.sv]
// ----------------------------------------------------------------------------
// tsl_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module tsl_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tsl_pkg::cmd_t   wdata,
  input  logic            pop,
  output tsl_pkg::cmd_t   rdata,
  output tsl_pkg::q_stat_t stat
);
  import tsl_pkg::*;

  cmd_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r;
  logic [QAW-1:0] rp_r;
  logic [QAW:0]   cnt_r;
  logic           do_push;
  logic           do_pop;

  assign stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == QAW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == QAW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[rtl/tsl_back.sv]
// ----------------------------------------------------------------------------
// tsl_back
// executes queued commands: target writes, timer divide, per-channel slew
// and the result register
// ----------------------------------------------------------------------------
module tsl_back (
  input  logic          clk,
  input  logic          rst_n,
  input  tsl_pkg::cmd_t cmd,
  input  logic          q_empty,
  output logic          pop,
  output logic          emit,
  tsl_cfg_if.sink       cfg_ch,
  tsl_out_if.source     out_ch
);
  import tsl_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_MUL,
    B_SLEW,
    B_EMIT
  } bstate_t;

  bstate_t                   st_r;
  logic signed [SPEED_W-1:0] tgt_r [CHANNELS];
  logic signed [SPEED_W-1:0] cur_r [CHANNELS];
  logic [TIMER_BITS-1:0]     last_r;
  logic [TPS_W-1:0]          tps_r;
  logic [REM_W-1:0]          rem_r;
  logic [TIMER_BITS-1:0]     quo_r;
  logic [DCNT_W-1:0]         dcnt_r;
  logic [STEP_W-1:0]         steps_r;
  logic [CH_W-1:0]           ch_r;
  logic                      ovalid_r;
  logic [DUTY_W-1:0]         duty_r [CHANNELS];
  logic [CHANNELS-1:0]       rev_r;

  logic [TPS_W-1:0]          tps_eff;
  logic [TIMER_BITS-1:0]     elapsed;
  logic [REM_W-1:0]          rem_sh;
  logic                      rem_ge;
  logic [STEP_W-1:0]         steps_sat;
  logic [PROD_W-1:0]         prod;
  logic signed [SPEED_W+1:0] cur_w;
  logic signed [SPEED_W+1:0] tgt_w;
  logic signed [SPEED_W+1:0] stp_w;
  logic signed [SPEED_W+1:0] mv_w;
  logic signed [SPEED_W+1:0] nxt_w;
  logic signed [SPEED_W-1:0] nxt_speed;
  logic                      out_free;

  assign cfg_ch.ready = 1'b1;
  assign tps_eff      = (tps_r == '0) ? TPS_W'(1) : tps_r;
  assign pop          = (st_r == B_IDLE) && !q_empty;
  assign emit         = (st_r == B_EMIT) && out_free;
  assign out_free     = !ovalid_r || out_ch.ready;

  // wrap rule: below the last time the span is one short of a full turn
  assign elapsed = (cmd.now >= last_r) ? cmd.now - last_r
                                       : cmd.now - last_r - 1'b1;

  assign rem_sh    = {rem_r[REM_W-2:0], quo_r[TIMER_BITS-1]};
  assign rem_ge    = (rem_sh >= REM_W'(tps_eff));
  assign steps_sat = (quo_r > TIMER_BITS'(STEP_SAT)) ? STEP_W'(STEP_SAT)
                                                     : STEP_W'(quo_r);
  assign prod      = PROD_W'(steps_sat) * PROD_W'(tps_eff);

  // slew of the selected channel
  always_comb begin
    cur_w = (SPEED_W+2)'(cur_r[ch_r]);
    tgt_w = (SPEED_W+2)'(tgt_r[ch_r]);
    stp_w = $signed((SPEED_W+2)'(steps_r));
    if (tgt_w > cur_w) begin
      mv_w  = cur_w + stp_w;
      nxt_w = (mv_w > tgt_w) ? tgt_w : mv_w;
    end else if (tgt_w < cur_w) begin
      mv_w  = cur_w - stp_w;
      nxt_w = (mv_w < tgt_w) ? tgt_w : mv_w;
    end else begin
      mv_w  = cur_w;
      nxt_w = cur_w;
    end
    // stop at zero before a change of direction
    if ((cur_w > 0 && nxt_w <= 0) || (cur_w < 0 && nxt_w >= 0)) nxt_w = '0;
    nxt_speed = SPEED_W'(nxt_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= B_IDLE;
      last_r   <= '0;
      tps_r    <= TPS_W'(TPS_RESET);
      ovalid_r <= 1'b0;
      dcnt_r   <= '0;
      ch_r     <= '0;
      for (int k = 0; k < CHANNELS; k++) begin
        tgt_r[k] <= '0;
        cur_r[k] <= '0;
      end
    end else begin
      if (cfg_ch.valid) tps_r <= cfg_ch.data;
      if (ovalid_r && out_ch.ready && !emit) ovalid_r <= 1'b0;
      case (st_r)
        B_IDLE: begin
          if (!q_empty) begin
            if (cmd.kind == CMD_TICK) begin
              if (elapsed < TIMER_BITS'(tps_eff)) begin
                st_r <= B_EMIT;
              end else begin
                rem_r  <= '0;
                quo_r  <= elapsed;
                dcnt_r <= '0;
                st_r   <= B_DIV;
              end
            end else begin
              for (int k = 0; k < CHANNELS; k++) begin
                if (cmd.mask[k]) tgt_r[k] <= cmd.speed;
              end
            end
          end
        end
        B_DIV: begin
          rem_r  <= rem_ge ? rem_sh - REM_W'(tps_eff) : rem_sh;
          quo_r  <= {quo_r[TIMER_BITS-2:0], rem_ge};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DCNT_W'(TIMER_BITS-1)) st_r <= B_MUL;
        end
        B_MUL: begin
          steps_r <= steps_sat;
          last_r  <= last_r + TIMER_BITS'(prod);
          ch_r    <= '0;
          st_r    <= B_SLEW;
        end
        B_SLEW: begin
          cur_r[ch_r] <= nxt_speed;
          ch_r        <= ch_r + 1'b1;
          if (ch_r == CH_W'(CHANNELS-1)) st_r <= B_EMIT;
        end
        B_EMIT: begin
          if (out_free) begin
            ovalid_r <= 1'b1;
            for (int k = 0; k < CHANNELS; k++) begin
              duty_r[k] <= {(cur_r[k][SPEED_W-1] ? SPEED_W'(-cur_r[k])
                                                 : SPEED_W'(cur_r[k])), 1'b0};
              rev_r[k]  <= cur_r[k][SPEED_W-1];
            end
            st_r <= B_IDLE;
          end
        end
        default: begin
          st_r <= B_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.duty_prop   = duty_r[0];
  assign out_ch.rev_prop    = rev_r[0];
  assign out_ch.duty_hbow   = duty_r[1];
  assign out_ch.rev_hbow    = rev_r[1];
  assign out_ch.duty_vbow   = duty_r[2];
  assign out_ch.rev_vbow    = rev_r[2];
  assign out_ch.duty_hstern = duty_r[3];
  assign out_ch.rev_hstern  = rev_r[3];
  assign out_ch.duty_vstern = duty_r[4];
  assign out_ch.rev_vstern  = rev_r[4];

endmodule

[rtl/thruster_slew_limiter.sv]
// ----------------------------------------------------------------------------
// thruster_slew_limiter
// five-channel thruster slew limiter: front classifies words into a short
// command queue, back runs the timer divide and the channel updates
// a tick word that takes a step passes a restoring divide, one multiply and
//   five channel updates before its result; with no step it goes straight out
// the back finishes a tick before it pops another command; sets are queued
// reset: synchronous, clears targets, speeds and last time, alive flag to one,
//   ticks_per_step to 1000; no clearing pass
// ----------------------------------------------------------------------------
module thruster_slew_limiter (
  input  logic      clk,
  input  logic      rst_n,
  tsl_in_if.sink    in_ch,
  tsl_out_if.source out_ch,
  tsl_cfg_if.sink   cfg_ch
);
  import tsl_pkg::*;

  cmd_t    push_cmd;
  cmd_t    head_cmd;
  logic    push;
  logic    pop;
  logic    emit;
  q_stat_t q_stat;

  tsl_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_stat.full),
    .push   (push),
    .cmd    (push_cmd)
  );

  tsl_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_cmd),
    .pop   (pop),
    .rdata (head_cmd),
    .stat  (q_stat)
  );

  tsl_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (head_cmd),
    .q_empty (q_stat.empty),
    .pop     (pop),
    .emit    (emit),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

  a_q_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty together");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.operation != OP_SET &&
     in_ch.operation != OP_TICK) |-> !push)
    else $error("command queued for a word without one");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(emit))
    else $error("result word without emit");

endmodule

[tb/thruster_slew_limiter_tb.sv]
// ----------------------------------------------------------------------------
// thruster_slew_limiter_tb
// Drives set, tick, alive and spare words into the slew limiter while the
// result side stalls on its own pattern. An in-bench model of the five channels,
// the timer step logic and the step size register predicts each result word a
// directed row does not give, and each received word is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thruster_slew_limiter_tb;
  import tsl_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [4:0][8:0] duty;
    logic [4:0]      rev;
  } thrust_rpt_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [4:0]        mask;
    logic signed [7:0] spd;
    logic [15:0]       now;
    logic              alv;
    logic              typed;
    logic [8:0]        exp_duty;
    logic [4:0]        exp_rev;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  tsl_in_if  in_ch ();
  tsl_out_if out_ch ();
  tsl_cfg_if cfg_ch ();

  thruster_slew_limiter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // channel state mirror
  logic signed [7:0] tgt_q [5];
  logic signed [7:0] spd_q [5];
  logic [15:0]       last_t;
  logic              alive_q;
  logic [15:0]       tps_q;

  thrust_rpt_t pending_rpt [$];
  int          err_cnt = 0;
  logic        word_typed;
  thrust_rpt_t word_rpt;
  int          rx_left = 0;
  int          rx_mode = 0;

  string ch_name [5] = '{"prop", "hbow", "vbow", "hstern", "vstern"};

  dir_row_t dir_rows [21] = '{
    '{OP_TICK,  5'h00, 8'h00, 16'd0,     1'b0, 1'b1, 9'd0, 5'h00},
    '{OP_SET,   5'h1F, 8'h7F, 16'h0000,  1'b0, 1'b0, 9'd0, 5'h00},
    '{OP_TICK,  5'h00, 8'h00, 16'd999,   1'b0, 1'b1, 9'd0, 5'h00},
    '{OP_TICK,  5'h00, 8'h00, 16'd1000,  1'b0, 1'b1, 9'd2, 5'h00},
    '{OP_TICK,  5'h1F, 8'hFF, 16'hFFFF,  1'b1, 1'b0, 9'd0, 5'h00},
    '{OP_TICK,  5'h00, 8'h00, 16'd0,     1'b0, 1'b0, 9'd0, 5'h00},
    '{OP_TICK,  5'h00, 8'h00, 16'd1000,  1'b0, 1'b0, 9'd0, 5'h00},
    '{OP_SET,   5'h01, 8'h80, 16'hFFFF,  1'b1, 1'b0, 9'd0, 5'h00},
    '{OP_SET,   5'h02, 8'h00, 16'h0000,  1'b0, 1'b0, 9'd0, 5'h00},
    '{OP_SET,   5'h04, 8'hFF, 16'h0000,  1'b0, 1'b0, 9'd0, 5'h00},
    '{OP_SET,   5'h00, 8'h7F, 16'h0000,  1'b0, 1'b0, 9'd0, 5'h00},
    '{OP_ALIVE, 5'h1F, 8'h7F, 16'hFFFF,  1'b0, 1'b0, 9'd0, 5'h00},
    '{OP_SET,   5'h1F, 8'h05, 16'h0000,  1'b0, 1'b0, 9'd0, 5'h00},
    '{OP_SPARE, 5'h1F, 8'h80, 16'hFFFF,  1'b1, 1'b0, 9'd0, 5'h00},
    '{OP_TICK,  5'h00, 8'h00, 16'hFFFF,  1'b0, 1'b0, 9'd0, 5'h00},
    '{OP_TICK,  5'h00, 8'h00, 16'd2000,  1'b0, 1'b0, 9'd0, 5'h00},
    '{OP_ALIVE, 5'h00, 8'h00, 16'h0000,  1'b1, 1'b0, 9'd0, 5'h00},
    '{OP_TICK,  5'h00, 8'h00, 16'd60000, 1'b0, 1'b0, 9'd0, 5'h00},
    '{OP_TICK,  5'h00, 8'h00, 16'd59999, 1'b0, 1'b0, 9'd0, 5'h00},
    '{OP_SET,   5'h1F, 8'h80, 16'h0000,  1'b0, 1'b0, 9'd0, 5'h00},
    '{OP_TICK,  5'h00, 8'h00, 16'd59000, 1'b0, 1'b0, 9'd0, 5'h00}
  };

  function automatic logic signed [7:0] slew_toward(logic signed [7:0] cur,
                                                    logic signed [7:0] tgt, int steps);
    int c;
    int t;
    int n;
    c = cur;
    t = tgt;
    if (c == t) return cur;
    if (t > c) begin
      n = (c + steps > t) ? t : c + steps;
    end else begin
      n = (c - steps < t) ? t : c - steps;
    end
    // no direct reversal, park at zero first
    if ((c > 0 && n < 0) || (c < 0 && n > 0)) n = 0;
    return 8'(n);
  endfunction

  function automatic thrust_rpt_t apply_tick(logic [15:0] now);
    thrust_rpt_t r;
    int unsigned tp;
    int unsigned el;
    int unsigned st;
    int a;
    tp = (tps_q == 16'd0) ? 1 : 32'(tps_q);
    if (now >= last_t) el = 32'(now) - 32'(last_t);
    else el = 32'(now) + 32'hFFFF - 32'(last_t);
    if (el >= tp) begin
      st = el / tp;
      if (st > 255) st = 255;
      last_t = 16'(32'(last_t) + st * tp);
      for (int k = 0; k < 5; k++) spd_q[k] = slew_toward(spd_q[k], tgt_q[k], int'(st));
    end
    for (int k = 0; k < 5; k++) begin
      a = spd_q[k];
      r.rev[k] = (a < 0);
      if (a < 0) a = -a;
      r.duty[k] = 9'(2 * a);
    end
    return r;
  endfunction

  task automatic report_miss(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic send_word(input logic [1:0] op, input logic [4:0] mask,
                           input logic signed [7:0] spd, input logic [15:0] now,
                           input logic alv);
    in_ch.operation    <= op;
    in_ch.motor_mask   <= mask;
    in_ch.target_speed <= spd;
    in_ch.timer_now    <= now;
    in_ch.alive_value  <= alv;
    in_ch.valid        <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_tps(input logic [15:0] v);
    cfg_ch.data  <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain_quiet();
    in_ch.valid <= 1'b0;
    while (pending_rpt.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // result side stall pattern
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = (rx_mode == 1) ? $urandom_range(1, 30) : $urandom_range(2, 60);
      end
      rx_left--;
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'b0;
        2: out_ch.ready <= ~out_ch.ready;
        default: out_ch.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk) begin
    thrust_rpt_t got;
    thrust_rpt_t want;
    thrust_rpt_t pred;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.duty[0] = out_ch.duty_prop;
        got.duty[1] = out_ch.duty_hbow;
        got.duty[2] = out_ch.duty_vbow;
        got.duty[3] = out_ch.duty_hstern;
        got.duty[4] = out_ch.duty_vstern;
        got.rev     = {out_ch.rev_vstern, out_ch.rev_hstern, out_ch.rev_vbow,
                       out_ch.rev_hbow, out_ch.rev_prop};
        if (pending_rpt.size() == 0) begin
          report_miss("result word with no tick pending");
        end else begin
          want = pending_rpt.pop_front();
          for (int k = 0; k < 5; k++) begin
            if (got.duty[k] !== want.duty[k])
              report_miss($sformatf("duty_%s: expected %0d, got %0d", ch_name[k],
                                    want.duty[k], got.duty[k]));
            if (got.rev[k] !== want.rev[k])
              report_miss($sformatf("rev_%s: expected %0d, got %0d", ch_name[k],
                                    want.rev[k], got.rev[k]));
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) tps_q = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.operation)
          OP_SET: begin
            if (alive_q) begin
              for (int k = 0; k < 5; k++)
                if (in_ch.motor_mask[k]) tgt_q[k] = in_ch.target_speed;
            end
          end
          OP_TICK: begin
            pred = apply_tick(in_ch.timer_now);
            pending_rpt.push_back(word_typed ? word_rpt : pred);
          end
          OP_ALIVE: alive_q = in_ch.alive_value;
          default: ;
        endcase
      end
    end
  end

  initial begin
    int sent;
    int burst_left;
    int gap;
    int r;
    int unsigned tp;
    int unsigned span;
    logic [15:0] tps_val;
    logic [1:0]  op;
    logic [4:0]  mask;
    logic signed [7:0] spd;
    logic [15:0] now;
    logic        alv;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_SET;
    in_ch.motor_mask   = 5'h00;
    in_ch.target_speed = 8'h00;
    in_ch.timer_now    = 16'h0000;
    in_ch.alive_value  = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = 16'h0000;
    word_typed         = 1'b0;
    word_rpt           = '0;
    for (int k = 0; k < 5; k++) begin
      tgt_q[k] = 8'sd0;
      spd_q[k] = 8'sd0;
    end
    last_t  = 16'h0000;
    alive_q = 1'b1;
    tps_q   = 16'(TPS_RESET);
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_tps(16'd1000);

    for (int i = 0; i < 21; i++) begin
      word_typed = dir_rows[i].typed;
      for (int k = 0; k < 5; k++) word_rpt.duty[k] = dir_rows[i].exp_duty;
      word_rpt.rev = dir_rows[i].exp_rev;
      send_word(dir_rows[i].op, dir_rows[i].mask, dir_rows[i].spd, dir_rows[i].now,
                dir_rows[i].alv);
    end
    word_typed = 1'b0;

    for (int p = 0; p < 7; p++) begin
      drain_quiet();
      case (p)
        0: tps_val = 16'd1;
        1: tps_val = 16'hFFFF;
        2: tps_val = 16'd0;
        3: tps_val = 16'($urandom_range(2, 300));
        4: tps_val = 16'($urandom_range(1, 65535));
        5: tps_val = 16'd1000;
        default: tps_val = 16'd1;
      endcase
      write_tps(tps_val);
      sent = 0;
      burst_left = $urandom_range(1, 24);
      while (sent < 72) begin
        mask = 5'($urandom);
        spd  = 8'($urandom);
        now  = 16'($urandom);
        alv  = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < 45) op = OP_TICK;
        else if (r < 80) op = OP_SET;
        else if (r < 93) op = OP_ALIVE;
        else op = OP_SPARE;
        if (op == OP_TICK) begin
          tp = (tps_q == 16'd0) ? 1 : 32'(tps_q);
          span = (tp * 300 > 65535) ? 65535 : tp * 300;
          r = $urandom_range(0, 99);
          if (r < 30) now = 16'(32'(last_t) + tp * $urandom_range(1, 3) - $urandom_range(0, 1));
          else if (r < 70) now = 16'(32'(last_t) + $urandom_range(0, span));
          else if (r < 85) now = 16'($urandom);
          else now = 16'(32'(last_t) - $urandom_range(0, 3));
        end else if (op == OP_SET) begin
          if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
              0: spd = 8'h80;
              1: spd = 8'h7F;
              2: spd = 8'h00;
              default: spd = 8'hFF;
            endcase
          end
        end else if (op == OP_ALIVE) begin
          alv = ($urandom_range(0, 4) != 0);
        end
        if (op != OP_SPARE && !(op == OP_SET && !alive_q)) sent++;
        send_word(op, mask, spd, now, alv);
        burst_left--;
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
          end
          burst_left = $urandom_range(1, 24);
        end
      end
    end

    drain_quiet();
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
